// File: rtl/particle_slab_collision_response_unit_macros.svh
`ifndef PARTICLE_SLAB_COLLISION_RESPONSE_UNIT_MACROS_SVH
`define PARTICLE_SLAB_COLLISION_RESPONSE_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define PSCR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pscr check failed");

// next-cycle implication, checked outside reset
`define PSCR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pscr check failed");

`endif

// File: rtl/pscr_pkg.sv
`default_nettype none

package pscr_pkg;

  localparam int DIV_BITS = 62;
  localparam int CNT_W = $clog2(DIV_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_BITS - 1);

  localparam logic [2:0] REG_HALF_SIDE  = 3'd0;
  localparam logic [2:0] REG_THICKNESS  = 3'd1;
  localparam logic [2:0] REG_POS_DAMP   = 3'd2;
  localparam logic [2:0] REG_ENERGY_DMP = 3'd3;
  localparam logic [2:0] REG_FRICTION   = 3'd4;
  localparam logic [2:0] REG_VEL_EPS    = 3'd5;

  typedef struct packed {
    logic [30:0] half_side;
    logic [30:0] thickness;
    logic [16:0] pos_damp;
    logic [16:0] energy_damp;
    logic [16:0] friction;
    logic [30:0] vel_eps;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic misc;
    logic div_step;
    logic fric_lo;
    logic fric_hi;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic back;
    logic div_done;
  } sts_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] u;
    u = v;
    return u[31] ? (~u + 32'd1) : u;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) r = 32'sh7fffffff;
    else if (v < -68'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/pscr_ctrl.sv
`default_nettype none

module pscr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           out_free,
  input  pscr_pkg::sts_t sts,
  output pscr_pkg::cmd_t cmd
);
  import pscr_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_PREP = 7'b0000010,
    ST_MISC = 7'b0000100,
    ST_DIV  = 7'b0001000,
    ST_FLO  = 7'b0010000,
    ST_FHI  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_next = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
        state_next = ST_MISC;
      end
      ST_MISC: begin
        cmd.misc = 1'b1;
        state_next = sts.back ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_next = ST_FLO;
      end
      ST_FLO: begin
        cmd.fric_lo = 1'b1;
        state_next = ST_FHI;
      end
      ST_FHI: begin
        cmd.fric_hi = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        cmd.finish = out_free;
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_ready = (state == ST_IDLE);

endmodule

`default_nettype wire

// File: rtl/pscr_dp.sv
`default_nettype none

module pscr_dp (
  input  logic           clk,
  input  logic           rst,
  input  pscr_pkg::cmd_t cmd,
  output pscr_pkg::sts_t sts,
  input  pscr_pkg::cfg_t cfg,
  input  logic [191:0]   in_data,
  output logic [223:0]   res_data,
  output logic           res_collided
);
  import pscr_pkg::*;

  logic signed [31:0] px, py, pz, vx, vy, vz;
  logic [31:0] apx, apy, az_c, avx, avy, avz_c;
  logic hit_c, back_c;
  logic hit_r, back_r;
  logic [31:0] az_r, avz_r;
  logic [63:0] num_x, num_y;

  logic signed [17:0] f_s, pd_s, ed_s, g_s;
  logic signed [32:0] opz, opv;
  logic signed [49:0] pvx, pvy;
  logic signed [50:0] pz_p, pv_p;

  logic [31:0] rem_x, rem_y;
  logic [DIV_BITS-1:0] q_x, q_y;
  logic [CNT_W-1:0] cnt;
  logic [32:0] t_x, t_y;
  logic ge_x, ge_y;

  logic signed [63:0] rx_c, ry_c;
  logic signed [50:0] plx, ply;
  logic signed [49:0] phx, phy;
  logic signed [81:0] sx, sy;
  logic signed [65:0] rrx, rry;

  logic signed [49:0] rvx, rvy;
  logic signed [50:0] rz, rvz;
  logic signed [67:0] z_extra;
  logic signed [31:0] nx, ny, nz, nvx, nvy, nvz;
  logic [30:0] peak, peak_c, avz_sat;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px <= in_data[31:0];
      py <= in_data[63:32];
      pz <= in_data[95:64];
      vx <= in_data[127:96];
      vy <= in_data[159:128];
      vz <= in_data[191:160];
    end
  end

  assign apx   = mag32(px);
  assign apy   = mag32(py);
  assign az_c  = mag32(pz);
  assign avx   = mag32(vx);
  assign avy   = mag32(vy);
  assign avz_c = mag32(vz);
  assign hit_c = pz[31] && (az_c < {1'b0, cfg.thickness}) &&
                 (apx <= {1'b0, cfg.half_side}) && (apy <= {1'b0, cfg.half_side});
  assign back_c = hit_c && (avz_c > {1'b0, cfg.vel_eps});

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      hit_r  <= hit_c;
      back_r <= back_c;
      az_r   <= az_c;
      avz_r  <= avz_c;
      num_x  <= avx * az_c;
      num_y  <= avy * az_c;
    end
  end

  assign f_s  = $signed({1'b0, cfg.friction});
  assign pd_s = $signed({1'b0, cfg.pos_damp});
  assign ed_s = $signed({1'b0, cfg.energy_damp});
  assign g_s  = f_s - 18'sd65536;

  // backtrack with vz > 0 reflects from the far side
  assign opz = (back_r && !vz[31]) ? -$signed({1'b0, az_r}) : $signed({1'b0, az_r});
  assign opv = back_r ? -33'(vz) : 33'(vz);

  always_ff @(posedge clk) begin
    if (cmd.misc) begin
      pvx  <= vx * f_s;
      pvy  <= vy * f_s;
      pz_p <= opz * pd_s;
      pv_p <= opv * ed_s;
    end
  end

  // restoring divider, x and y lanes share the divisor
  assign t_x  = {rem_x, q_x[DIV_BITS-1]};
  assign t_y  = {rem_y, q_y[DIV_BITS-1]};
  assign ge_x = t_x >= {1'b0, avz_r};
  assign ge_y = t_y >= {1'b0, avz_r};

  always_ff @(posedge clk) begin
    if (cmd.misc) begin
      rem_x <= '0;
      rem_y <= '0;
      q_x   <= num_x[DIV_BITS-1:0];
      q_y   <= num_y[DIV_BITS-1:0];
      cnt   <= '0;
    end else if (cmd.div_step) begin
      rem_x <= ge_x ? 32'(t_x - {1'b0, avz_r}) : t_x[31:0];
      rem_y <= ge_y ? 32'(t_y - {1'b0, avz_r}) : t_y[31:0];
      q_x   <= {q_x[DIV_BITS-2:0], ge_x};
      q_y   <= {q_y[DIV_BITS-2:0], ge_y};
      cnt   <= cnt + 1'b1;
    end
  end

  assign sts.div_done = (cnt == CNT_LAST);
  assign sts.back     = back_r;

  // offset times (friction - 1), split in 32-bit halves
  assign rx_c = vx[31] ? -$signed({2'b0, q_x}) : $signed({2'b0, q_x});
  assign ry_c = vy[31] ? -$signed({2'b0, q_y}) : $signed({2'b0, q_y});

  always_ff @(posedge clk) begin
    if (cmd.fric_lo) begin
      plx <= $signed({1'b0, rx_c[31:0]}) * g_s;
      ply <= $signed({1'b0, ry_c[31:0]}) * g_s;
      phx <= $signed(rx_c[63:32]) * g_s;
      phy <= $signed(ry_c[63:32]) * g_s;
    end
  end

  assign sx = (82'(phx) <<< 32) + 82'(plx) + 82'sd32768;
  assign sy = (82'(phy) <<< 32) + 82'(ply) + 82'sd32768;

  always_ff @(posedge clk) begin
    if (cmd.fric_hi) begin
      rrx <= 66'(sx >>> 16);
      rry <= 66'(sy >>> 16);
    end
  end

  assign rvx = (pvx + 50'sd32768) >>> 16;
  assign rvy = (pvy + 50'sd32768) >>> 16;
  assign rz  = (pz_p + 51'sd32768) >>> 16;
  assign rvz = (pv_p + 51'sd32768) >>> 16;
  assign z_extra = (back_r && !vz[31]) ? -(68'sd2 * 68'($signed({1'b0, az_r}))) : 68'sd0;

  always_comb begin
    nx = px; ny = py; nz = pz; nvx = vx; nvy = vy; nvz = vz;
    if (hit_r) begin
      if (back_r) begin
        nx = sat32(68'(px) + 68'(rrx));
        ny = sat32(68'(py) + 68'(rry));
      end
      nz  = sat32(68'(rz) + z_extra);
      nvx = sat32(68'(rvx));
      nvy = sat32(68'(rvy));
      nvz = sat32(68'(rvz));
    end
  end

  assign avz_sat = avz_r[31] ? 31'h7fffffff : avz_r[30:0];
  assign peak_c  = (hit_r && (avz_r > {1'b0, peak})) ? avz_sat : peak;

  always_ff @(posedge clk) begin
    if (rst) peak <= '0;
    else if (cmd.finish) peak <= peak_c;
  end

  assign res_data = {1'b0, peak_c, nvz, nvy, nvx, nz, ny, nx};
  assign res_collided = hit_r;

endmodule

`default_nettype wire

// File: rtl/particle_slab_collision_response_unit.sv
// without backtrack an item runs load, prep and misc, then finish once the output is free
// with backtrack the 62-step restoring divider and both friction steps come before finish
// a new item is taken once the previous result sits in the output register
// reset (rst, synchronous, active high) clears the controller, the output valid,
// the peak normal speed, and loads the configuration reset values
`default_nettype none

`include "particle_slab_collision_response_unit_macros.svh"

module particle_slab_collision_response_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z, peak_normal_speed
  output logic [223:0] m_axis_tdata,
  output logic         m_axis_tuser,  // collided
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [30:0]  cfg_data
);
  import pscr_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;
  logic out_free;
  logic [223:0] res_data;
  logic res_collided;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_side   <= 31'd65536;
      cfg.thickness   <= 31'd327680;
      cfg.pos_damp    <= 17'd65536;
      cfg.energy_damp <= 17'd65536;
      cfg.friction    <= 17'd65536;
      cfg.vel_eps     <= 31'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HALF_SIDE:  cfg.half_side   <= cfg_data;
        REG_THICKNESS:  cfg.thickness   <= cfg_data;
        REG_POS_DAMP:   cfg.pos_damp    <= cfg_data[16:0];
        REG_ENERGY_DMP: cfg.energy_damp <= cfg_data[16:0];
        REG_FRICTION:   cfg.friction    <= cfg_data[16:0];
        REG_VEL_EPS:    cfg.vel_eps     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_free = !m_axis_tvalid || m_axis_tready;

  pscr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  pscr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg          (cfg),
    .in_data      (s_axis_tdata),
    .res_data     (res_data),
    .res_collided (res_collided)
  );

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (cmd.finish) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_axis_tdata <= res_data;
      m_axis_tuser <= res_collided;
    end
  end

  `PSCR_ASSERT_IMP(a_finish_free, cmd.finish, out_free)
  `PSCR_ASSERT_NXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `PSCR_ASSERT_IMP(a_take_not_finish, s_axis_tvalid && s_axis_tready, !cmd.finish)

endmodule

`default_nettype wire

// File: dv/pscr_checker.sv
`default_nettype none

module pscr_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [223:0] m_axis_tdata,
  input  logic         m_axis_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [30:0]  cfg_data,
  output int           fails,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import pscr_pkg::*;

  typedef struct packed {
    logic         collided;
    logic [223:0] data;
  } response_t;

  response_t   response_q[$];
  cfg_t        slab_cfg;
  logic [30:0] peak_speed;

  string field_name[7] = '{"new_pos_x", "new_pos_y", "new_pos_z", "new_vel_x", "new_vel_y",
                           "new_vel_z", "peak_normal_speed"};

  function automatic longint rnd_scale(longint a, longint f);
    return (a * f + 32768) >>> 16;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // (v * num) / den, truncated toward zero
  function automatic longint trunc_scale(longint v, longint num, longint den);
    longint m;
    longint q;
    m = (v < 0) ? -v : v;
    q = (m * num) / den;
    return (v < 0) ? -q : q;
  endfunction

  // p - r + rnd(r * f), split so the product cannot overflow
  function automatic longint friction_off(longint p, longint r, longint f);
    longint hi;
    longint lo;
    longint part;
    hi = r >>> 16;
    lo = r - hi * 65536;
    part = (lo * f + 32768) / 65536;
    return p + hi * (f - 65536) - lo + part;
  endfunction

  function automatic response_t collide(logic [191:0] d);
    longint px, py, pz, vx, vy, vz;
    longint nx, ny, nz, nvx, nvy, nvz;
    longint az, avz, rx, ry, rz;
    logic hit;
    response_t r;
    px = longint'($signed(d[31:0]));
    py = longint'($signed(d[63:32]));
    pz = longint'($signed(d[95:64]));
    vx = longint'($signed(d[127:96]));
    vy = longint'($signed(d[159:128]));
    vz = longint'($signed(d[191:160]));
    nx = px; ny = py; nz = pz; nvx = vx; nvy = vy; nvz = vz;
    az = (pz < 0) ? -pz : pz;
    avz = (vz < 0) ? -vz : vz;
    hit = pz < 0 && az < longint'(slab_cfg.thickness)
          && ((px < 0) ? -px : px) <= longint'(slab_cfg.half_side)
          && ((py < 0) ? -py : py) <= longint'(slab_cfg.half_side);
    if (hit) begin
      if (avz > longint'(peak_speed))
        peak_speed = (avz > 64'sd2147483647) ? 31'h7fffffff : avz[30:0];
      if (avz <= longint'(slab_cfg.vel_eps)) begin
        nz = rnd_scale(-pz, slab_cfg.pos_damp);
        nvz = rnd_scale(vz, slab_cfg.energy_damp);
      end else begin
        rx = trunc_scale(vx, az, avz);
        ry = trunc_scale(vy, az, avz);
        rz = (vz < 0) ? -az : az;
        nx = friction_off(px, rx, slab_cfg.friction);
        ny = friction_off(py, ry, slab_cfg.friction);
        nz = pz - rz + rnd_scale(-rz, slab_cfg.pos_damp);
        nvz = rnd_scale(-vz, slab_cfg.energy_damp);
      end
      nvx = rnd_scale(vx, slab_cfg.friction);
      nvy = rnd_scale(vy, slab_cfg.friction);
    end
    r.collided = hit;
    r.data = {1'b0, peak_speed, clamp32(nvz), clamp32(nvy), clamp32(nvx),
              clamp32(nz), clamp32(ny), clamp32(nx)};
    return r;
  endfunction

  assign pending = response_q.size();

  always @(posedge clk) begin
    response_t want;
    int errs;
    errs = 0;
    if (rst) begin
      response_q.delete();
      slab_cfg.half_side   <= 31'd65536;
      slab_cfg.thickness   <= 31'd327680;
      slab_cfg.pos_damp    <= 17'd65536;
      slab_cfg.energy_damp <= 17'd65536;
      slab_cfg.friction    <= 17'd65536;
      slab_cfg.vel_eps     <= 31'd1;
      peak_speed = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HALF_SIDE:  slab_cfg.half_side   <= cfg_data;
          REG_THICKNESS:  slab_cfg.thickness   <= cfg_data;
          REG_POS_DAMP:   slab_cfg.pos_damp    <= cfg_data[16:0];
          REG_ENERGY_DMP: slab_cfg.energy_damp <= cfg_data[16:0];
          REG_FRICTION:   slab_cfg.friction    <= cfg_data[16:0];
          REG_VEL_EPS:    slab_cfg.vel_eps     <= cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) response_q.push_back(collide(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (response_q.size() == 0) begin
          $error("unexpected result transfer");
          errs++;
        end else begin
          want = response_q.pop_front();
          for (int i = 0; i < 6; i++) begin
            if (m_axis_tdata[32*i +: 32] !== want.data[32*i +: 32]) begin
              $error("%s expected %h actual %h", field_name[i], want.data[32*i +: 32],
                     m_axis_tdata[32*i +: 32]);
              errs++;
            end
          end
          if (m_axis_tdata[222:192] !== want.data[222:192]) begin
            $error("%s expected %h actual %h", field_name[6], want.data[222:192],
                   m_axis_tdata[222:192]);
            errs++;
          end
          if (m_axis_tuser !== want.collided) begin
            $error("collided expected %b actual %b", want.collided, m_axis_tuser);
            errs++;
          end
        end
      end
      if (errs != 0) fails <= fails + errs;
    end
  end

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pscr_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [223:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = REG_HALF_SIDE;
  logic [30:0]  cfg_data = '0;
  int           fails;
  int           pending;

  bit           idle_on = 1'b1;
  bit           hold_req = 1'b0;
  bit           hold_taken = 1'b0;
  int           hold_cycles = 0;
  logic [30:0]  cur_half = 31'd65536;
  logic [30:0]  cur_thick = 31'd327680;

  particle_slab_collision_response_unit dut (.*);

  pscr_checker checker_i (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  // receiver: long hold-off when requested, else random stalls while idle_on is set
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cycles <= 600;
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= idle_on ? ($urandom_range(99) >= 38) : 1'b1;
    end
  end

  task automatic send(input logic [31:0] px, py, pz, vx, vy, vz);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {vz, vy, vx, pz, py, px};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (idle_on && $urandom_range(99) < 38) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == REG_HALF_SIDE) cur_half = val;
    if (idx == REG_THICKNESS) cur_thick = val;
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic load_slab(input logic [30:0] hs, th, pd, ed, fr, eps);
    set_reg(REG_HALF_SIDE, hs);
    set_reg(REG_THICKNESS, th);
    set_reg(REG_POS_DAMP, pd);
    set_reg(REG_ENERGY_DMP, ed);
    set_reg(REG_FRICTION, fr);
    set_reg(REG_VEL_EPS, eps);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] wide_rand();
    logic [31:0] v;
    v = $urandom();
    return $signed(v) >>> $urandom_range(0, 31);
  endfunction

  function automatic logic [31:0] in_range(input logic [30:0] lim);
    logic [31:0] v;
    v = {1'b0, 31'($urandom_range(0, lim))};
    return $urandom_range(1) ? -v : v;
  endfunction

  task automatic random_particle;
    logic [31:0] px, py, pz;
    if ($urandom_range(99) < 75) begin
      px = in_range(cur_half);
      py = in_range(cur_half);
      pz = (cur_thick > 1) ? -{1'b0, 31'($urandom_range(1, cur_thick - 1))} : -32'd1;
    end else begin
      px = wide_rand();
      py = wide_rand();
      pz = wide_rand();
    end
    send(px, py, pz, wide_rand(), wide_rand(), wide_rand());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset configuration
    send(0, 0, 0, 0, 0, 0);
    send(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send(0, 0, -32'sd65536, 32'd1000, -32'sd1000, 0);
    send(0, 0, -32'sd65536, 32'd70000, -32'sd70000, 32'd1);
    send(32'd65536, -32'sd65536, -32'sd1, 32'd131072, 32'd5, -32'sd131072);
    send(32'd65537, 0, -32'sd100, 0, 0, 32'd500000);
    send(0, 32'd65537, -32'sd100, 0, 0, 32'd500000);
    send(0, 0, -32'sd327680, 0, 0, 32'd500000);
    send(0, 0, -32'sd327679, 32'h7fffffff, 32'h80000000, 32'd2);
    send(0, 0, -32'sd327679, 32'h7fffffff, 32'h80000000, 32'h80000000);
    send(-32'sd65536, 32'd12345, -32'sd4000, -32'sd99999, 32'd77777, 32'h7fffffff);
    drain();

    // extremes of the registers
    load_slab(31'h7fffffff, 31'h7fffffff, 31'd131071, 31'd131071, 31'd131071, 31'd0);
    send(32'h7fffffff, 32'h80000001, 32'h80000001, 32'h7fffffff, 32'h80000000, 32'd1);
    send(0, 0, 32'h80000001, 32'h7fffffff, 32'h80000000, 32'h80000000);
    send(32'h80000000, 0, -32'sd5, 0, 0, 0);
    send(32'h40000000, -32'sd3, 32'hc0000000, 32'h12345678, 32'hedcba987, 32'd3);
    drain();
    load_slab(31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'h7fffffff);
    send(0, 0, -32'sd1, 32'd5, 32'd5, 32'd5);
    send(0, 0, 0, 32'd5, 32'd5, 32'd5);
    drain();
    load_slab(31'd1, 31'd2, 31'd0, 31'd0, 31'd0, 31'h7fffffff);
    send(32'd1, -32'sd1, -32'sd1, 32'h7fffffff, 32'h80000000, 32'h80000000);
    send(0, 0, -32'sd1, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_slab(31'd65536, 31'd327680, 31'd65536, 31'd65536, 31'd65536, 31'd1);
        1: load_slab(31'h7fffffff, 31'h7fffffff, 31'd131071, 31'd131071, 31'd131071, 31'd0);
        2: load_slab(31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'h7fffffff);
        default: load_slab(31'($urandom()), 31'($urandom()), 31'($urandom_range(0, 131071)),
                           31'($urandom_range(0, 131071)), 31'($urandom_range(0, 131071)),
                           31'($urandom()) >> $urandom_range(0, 30));
      endcase
      idle_on = (ph != 4);
      if (ph == 3) hold_req = 1'b1;
      for (int k = 0; k < 100; k++) random_particle();
      // sender stops until everything has come back
      drain();
    end

    idle_on = 1'b1;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/pscr_pkg.sv
rtl/pscr_ctrl.sv
rtl/pscr_dp.sv
rtl/particle_slab_collision_response_unit.sv
dv/pscr_checker.sv
dv/tb_top.sv
